>>> rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// types, codes and helpers shared by the i2c master byte engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam logic [7:0] HOLD_TICKS_RST      = 8'd6;
	localparam logic [7:0] BIT_PHASE_TICKS_RST = 8'd2;
	localparam logic [7:0] ACK_TIMEOUT_RST     = 8'd250;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_HOLD_TICKS      = 2'd0,
		REG_BIT_PHASE_TICKS = 2'd1,
		REG_ACK_TIMEOUT     = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_ST_A     = 4'd1,
		PH_ST_B     = 4'd2,
		PH_SP_A     = 4'd3,
		PH_SP_B     = 4'd4,
		PH_SP_C     = 4'd5,
		PH_W_LOW    = 4'd6,
		PH_W_HIGH   = 4'd7,
		PH_W_TAIL   = 4'd8,
		PH_ACK_REL  = 4'd9,
		PH_ACK_WAIT = 4'd10,
		PH_R_LOW    = 4'd11,
		PH_R_HIGH   = 4'd12,
		PH_A_LOW    = 4'd13,
		PH_A_HIGH   = 4'd14
	} phase_t;

	typedef struct packed {
		logic [7:0] hold_ticks;
		logic [7:0] bit_phase_ticks;
		logic [7:0] ack_timeout;
	} i2cm_cfg_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] opcode;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} i2cm_in_t;

	typedef struct packed {
		logic       scl;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_missing;
	} i2cm_out_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic drv;
	} line_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] bit_count;
		logic [7:0] shift_reg;
		logic [7:0] tick_count;
		logic [7:0] wait_count;
		logic [7:0] rx_hold;
		logic       ack_flag;
		logic       ack_mode;
		line_t      line;
	} i2cm_state_t;

	localparam i2cm_state_t STATE_RST = '{
		phase:      PH_IDLE,
		bit_count:  4'd0,
		shift_reg:  8'd0,
		tick_count: 8'd0,
		wait_count: 8'd0,
		rx_hold:    8'd0,
		ack_flag:   1'b0,
		ack_mode:   1'b0,
		line:       '{scl: 1'b1, sda: 1'b1, drv: 1'b1}
	};

	function automatic logic [7:0] len_less_one(input logic [7:0] n);
		return (n == 8'd0) ? 8'd0 : n - 8'd1;
	endfunction

endpackage

>>> rtl/i2cm_in_if.sv
// ----------------------------------------------------------------------------
// i2cm_in_if
// tick/command channel into the engine
// ----------------------------------------------------------------------------
interface i2cm_in_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [1:0] opcode;
	logic [7:0] tx_byte;
	logic       send_ack;
	logic       sda_in;

	modport source (output valid, cmd_valid, opcode, tx_byte, send_ack, sda_in, input ready);
	modport sink (input valid, cmd_valid, opcode, tx_byte, send_ack, sda_in, output ready);
endinterface

>>> rtl/i2cm_out_if.sv
// ----------------------------------------------------------------------------
// i2cm_out_if
// per-tick result channel out of the engine
// ----------------------------------------------------------------------------
interface i2cm_out_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda_level;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_missing;

	modport source (output valid, scl, sda_level, sda_drive, busy_res, done_res, rx_byte,
		ack_missing, input ready);
	modport sink (input valid, scl, sda_level, sda_drive, busy_res, done_res, rx_byte,
		ack_missing, output ready);
endinterface

>>> rtl/i2cm_cfg_if.sv
// ----------------------------------------------------------------------------
// i2cm_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface i2cm_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/i2cm_cfg_regs.sv
// ----------------------------------------------------------------------------
// i2cm_cfg_regs
// timing registers, written through the config channel
// ----------------------------------------------------------------------------
module i2cm_cfg_regs
	import i2cm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	i2cm_cfg_if.sink         cfg,
	output i2cm_cfg_t        regs
);

	i2cm_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.hold_ticks      <= HOLD_TICKS_RST;
			regs_q.bit_phase_ticks <= BIT_PHASE_TICKS_RST;
			regs_q.ack_timeout     <= ACK_TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_HOLD_TICKS:      regs_q.hold_ticks      <= cfg.data;
				REG_BIT_PHASE_TICKS: regs_q.bit_phase_ticks <= cfg.data;
				REG_ACK_TIMEOUT:     regs_q.ack_timeout     <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// bus sequencer state and its one-tick update
// ----------------------------------------------------------------------------
module i2cm_core
	import i2cm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  i2cm_in_t   din,
	input  i2cm_cfg_t  regs,
	output i2cm_out_t  res
);

	i2cm_state_t st_q;
	i2cm_state_t st_d;
	logic        done;
	logic        ent;
	phase_t      ent_ph;

	always_comb begin
		st_d   = st_q;
		done   = 1'b0;
		ent    = 1'b0;
		ent_ph = PH_IDLE;

		if (st_q.phase == PH_IDLE) begin
			if (din.cmd_valid) begin
				st_d.bit_count = 4'd0;
				ent = 1'b1;
				case (opcode_t'(din.opcode))
					OP_START: ent_ph = PH_ST_A;
					OP_STOP:  ent_ph = PH_SP_A;
					OP_WRITE: begin
						st_d.shift_reg = din.tx_byte;
						ent_ph = PH_W_LOW;
					end
					OP_READ: begin
						st_d.shift_reg = 8'd0;
						st_d.ack_mode = din.send_ack;
						ent_ph = PH_R_LOW;
					end
					default: ent = 1'b0;
				endcase
			end
		end else if (st_q.phase == PH_ACK_WAIT) begin
			if (!din.sda_in) begin
				st_d.ack_flag   = 1'b0;
				st_d.line       = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
				st_d.phase      = PH_IDLE;
				st_d.tick_count = 8'd0;
				done            = 1'b1;
			end else if (st_q.wait_count >= regs.ack_timeout) begin
				st_d.ack_flag = 1'b1;
				ent    = 1'b1;
				ent_ph = PH_SP_A;
			end else begin
				st_d.wait_count = st_q.wait_count + 8'd1;
			end
		end else if (st_q.tick_count != 8'd0) begin
			st_d.tick_count = st_q.tick_count - 8'd1;
		end else begin
			case (st_q.phase)
				PH_ST_A: begin ent = 1'b1; ent_ph = PH_ST_B; end
				PH_ST_B: begin
					st_d.line       = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
					st_d.phase      = PH_IDLE;
					st_d.tick_count = 8'd0;
					done            = 1'b1;
				end
				PH_SP_A: begin ent = 1'b1; ent_ph = PH_SP_B; end
				PH_SP_B: begin ent = 1'b1; ent_ph = PH_SP_C; end
				PH_SP_C: begin
					st_d.line       = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
					st_d.phase      = PH_IDLE;
					st_d.tick_count = 8'd0;
					done            = 1'b1;
				end
				PH_W_LOW:  begin ent = 1'b1; ent_ph = PH_W_HIGH; end
				PH_W_HIGH: begin ent = 1'b1; ent_ph = PH_W_TAIL; end
				PH_W_TAIL: begin
					st_d.shift_reg = {st_q.shift_reg[6:0], 1'b0};
					st_d.bit_count = st_q.bit_count + 4'd1;
					ent    = 1'b1;
					ent_ph = st_d.bit_count[3] ? PH_ACK_REL : PH_W_LOW;
				end
				PH_ACK_REL: begin ent = 1'b1; ent_ph = PH_ACK_WAIT; end
				PH_R_LOW: begin
					st_d.shift_reg = {st_q.shift_reg[6:0], din.sda_in};
					ent    = 1'b1;
					ent_ph = PH_R_HIGH;
				end
				PH_R_HIGH: begin
					st_d.bit_count = st_q.bit_count + 4'd1;
					ent = 1'b1;
					if (st_d.bit_count[3]) begin
						st_d.rx_hold = st_q.shift_reg;
						ent_ph = PH_A_LOW;
					end else begin
						ent_ph = PH_R_LOW;
					end
				end
				PH_A_LOW: begin ent = 1'b1; ent_ph = PH_A_HIGH; end
				PH_A_HIGH: begin
					st_d.line       = '{scl: 1'b0, sda: st_q.line.sda, drv: 1'b1};
					st_d.phase      = PH_IDLE;
					st_d.tick_count = 8'd0;
					done            = 1'b1;
				end
				default: st_d.phase = PH_IDLE;
			endcase
		end

		// entering a segment: lines and segment length
		if (ent) begin
			st_d.phase      = ent_ph;
			st_d.tick_count = 8'd0;
			case (ent_ph)
				PH_ST_A: begin
					st_d.line       = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
					st_d.tick_count = len_less_one(regs.hold_ticks);
				end
				PH_ST_B: begin
					st_d.line       = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
					st_d.tick_count = len_less_one(regs.hold_ticks);
				end
				PH_SP_A: st_d.line = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
				PH_SP_B: begin
					st_d.line       = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
					st_d.tick_count = len_less_one(regs.hold_ticks);
				end
				PH_SP_C: begin
					st_d.line       = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
					st_d.tick_count = len_less_one(regs.hold_ticks);
				end
				PH_W_LOW: begin
					st_d.line       = '{scl: 1'b0, sda: st_d.shift_reg[7], drv: 1'b1};
					st_d.tick_count = len_less_one(regs.bit_phase_ticks);
				end
				PH_W_HIGH, PH_A_HIGH: begin
					st_d.line       = '{scl: 1'b1, sda: st_q.line.sda, drv: 1'b1};
					st_d.tick_count = len_less_one(regs.bit_phase_ticks);
				end
				PH_W_TAIL: begin
					st_d.line       = '{scl: 1'b0, sda: st_q.line.sda, drv: 1'b1};
					st_d.tick_count = len_less_one(regs.bit_phase_ticks);
				end
				PH_ACK_REL: st_d.line = '{scl: 1'b0, sda: 1'b1, drv: 1'b1};
				PH_ACK_WAIT: begin
					st_d.line       = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
					st_d.wait_count = 8'd0;
				end
				PH_R_LOW: begin
					st_d.line       = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
					st_d.tick_count = len_less_one(regs.bit_phase_ticks);
				end
				PH_R_HIGH: begin
					st_d.line       = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
					st_d.tick_count = len_less_one(regs.bit_phase_ticks);
				end
				PH_A_LOW: begin
					st_d.line       = '{scl: 1'b0, sda: ~st_d.ack_mode, drv: 1'b1};
					st_d.tick_count = len_less_one(regs.bit_phase_ticks);
				end
				default: st_d.phase = PH_IDLE;
			endcase
		end
	end

	always_comb begin
		res.scl         = st_d.line.scl;
		res.sda_level   = st_d.line.sda;
		res.sda_drive   = st_d.line.drv;
		res.busy_res    = (st_d.phase != PH_IDLE);
		res.done_res    = done;
		res.rx_byte     = st_d.rx_hold;
		res.ack_missing = st_d.ack_flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RST;
		end else if (en) begin
			st_q <= st_d;
		end
	end

endmodule

>>> rtl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// i2c master bit engine advanced by one timing tick per input beat
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  cmd_in    in   valid/ready    cmd_valid opcode tx_byte send_ack sda_in
//  res_out   out  valid/ready    scl sda_level sda_drive busy_res done_res
//                                rx_byte ack_missing
//  cfg       in   valid/ready    index data (ready always high)
//
// one tick beat per clock while the result side does not stall; a result passes
// the input register, then the sequencer update into the result register
// reset puts the sequencer idle with scl high and sda driven high
// a stalled result holds; input keeps flowing until the input register and
// the result register are both full
module i2c_master_byte_engine
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	i2cm_in_if.sink     cmd_in,
	i2cm_out_if.source  res_out,
	i2cm_cfg_if.sink    cfg
);

	i2cm_cfg_t regs;
	i2cm_in_t  in_s1;
	logic      vld_s1;
	i2cm_out_t res;
	i2cm_out_t res_q;
	logic      res_vld_q;
	logic      adv;
	logic      in_ready;

	assign adv      = vld_s1 && (!res_vld_q || res_out.ready);
	assign in_ready = !vld_s1 || adv;

	assign cmd_in.ready = in_ready;

	i2cm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	i2cm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.din    (in_s1),
		.regs   (regs),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= cmd_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && cmd_in.valid) begin
			in_s1 <= '{cmd_valid: cmd_in.cmd_valid, opcode: cmd_in.opcode,
				tx_byte: cmd_in.tx_byte, send_ack: cmd_in.send_ack, sda_in: cmd_in.sda_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= 1'b1;
		end else if (res_out.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign res_out.valid       = res_vld_q;
	assign res_out.scl         = res_q.scl;
	assign res_out.sda_level   = res_q.sda_level;
	assign res_out.sda_drive   = res_q.sda_drive;
	assign res_out.busy_res    = res_q.busy_res;
	assign res_out.done_res    = res_q.done_res;
	assign res_out.rx_byte     = res_q.rx_byte;
	assign res_out.ack_missing = res_q.ack_missing;

endmodule

>>> rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// i2cm_checker
// port-level checks on the i2c master byte engine
// ----------------------------------------------------------------------------
module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_busy,
	input logic       out_done,
	input logic [7:0] out_rx,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	// result beat held while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_rx) && $stable(out_done))
		else $error("result beat changed while stalled");

	// empty result register never backpressures input
	a_in_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// a completing tick leaves the engine idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_done |-> !out_busy)
		else $error("done with busy set");

	// config writes never stall
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (cmd_in.ready),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.out_busy  (res_out.busy_res),
	.out_done  (res_out.done_res),
	.out_rx    (res_out.rx_byte),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the i2c master byte engine: a tick generator steers
// well-formed start/write/read/stop traffic with ack timing and random noise,
// a predictor tracks the sequencer on every accepted tick beat, and every
// result beat is compared field by field under random stalls on both sides
// and several register settings, extremes included
// ----------------------------------------------------------------------------
module tb;
	import i2cm_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int LONG_HOLD   = 400;
	localparam int MAX_LINES   = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	i2cm_in_if  cmd_in();
	i2cm_out_if res_out();
	i2cm_cfg_if reg_bus();

	i2cm_in_t   beat = '0;
	logic       beat_valid = 1'b0;
	logic       take_ready = 1'b0;
	logic       reg_valid = 1'b0;
	logic [1:0] reg_index = '0;
	logic [7:0] reg_data = '0;

	assign cmd_in.valid     = beat_valid;
	assign cmd_in.cmd_valid = beat.cmd_valid;
	assign cmd_in.opcode    = beat.opcode;
	assign cmd_in.tx_byte   = beat.tx_byte;
	assign cmd_in.send_ack  = beat.send_ack;
	assign cmd_in.sda_in    = beat.sda_in;
	assign res_out.ready    = take_ready;
	assign reg_bus.valid    = reg_valid;
	assign reg_bus.index    = reg_index;
	assign reg_bus.data     = reg_data;

	i2c_master_byte_engine dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_in  (cmd_in),
		.res_out (res_out),
		.cfg     (reg_bus)
	);

	i2cm_in_t    tick_q[$];
	i2cm_out_t   line_q[$];
	i2cm_state_t seq_st;
	i2cm_state_t gen_st;
	i2cm_cfg_t   seq_cfg;
	i2cm_cfg_t   gen_cfg;
	int          gen_ticks = 0;
	int          ack_hold = 0;
	int          errors = 0;
	int          res_count = 0;
	int          send_gap = 0;
	int          take_gap = 0;
	int          hold_left = 0;
	bit          hold_used = 1'b0;
	bit          hold_req = 1'b0;
	bit          send_lazy = 1'b0;
	bit          take_lazy = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// sequencer predictor
	function automatic logic [7:0] seg_ticks(input logic [7:0] n);
		return (n > 8'd1) ? n - 8'd1 : 8'd0;
	endfunction

	function automatic i2cm_state_t idle_state();
		i2cm_state_t s;
		s = '0;
		s.phase = PH_IDLE;
		s.line = {1'b1, 1'b1, 1'b1};
		return s;
	endfunction

	function automatic void enter_phase(inout i2cm_state_t s, input i2cm_cfg_t c,
		input phase_t ph);
		s.phase = ph;
		s.tick_count = '0;
		case (ph)
			PH_ST_A: begin
				s.line = {1'b1, 1'b1, 1'b1};
				s.tick_count = seg_ticks(c.hold_ticks);
			end
			PH_ST_B: begin
				s.line = {1'b1, 1'b0, 1'b1};
				s.tick_count = seg_ticks(c.hold_ticks);
			end
			PH_SP_A: s.line = {1'b0, 1'b0, 1'b1};
			PH_SP_B: begin
				s.line = {1'b1, 1'b0, 1'b1};
				s.tick_count = seg_ticks(c.hold_ticks);
			end
			PH_SP_C: begin
				s.line = {1'b1, 1'b1, 1'b1};
				s.tick_count = seg_ticks(c.hold_ticks);
			end
			PH_W_LOW: begin
				s.line = {1'b0, s.shift_reg[7], 1'b1};
				s.tick_count = seg_ticks(c.bit_phase_ticks);
			end
			PH_W_HIGH: begin
				s.line = {1'b1, s.line.sda, 1'b1};
				s.tick_count = seg_ticks(c.bit_phase_ticks);
			end
			PH_W_TAIL: begin
				s.line = {1'b0, s.line.sda, 1'b1};
				s.tick_count = seg_ticks(c.bit_phase_ticks);
			end
			PH_ACK_REL: s.line = {1'b0, 1'b1, 1'b1};
			PH_ACK_WAIT: begin
				s.line = {1'b1, 1'b1, 1'b0};
				s.wait_count = '0;
			end
			PH_R_LOW: begin
				s.line = {1'b0, 1'b1, 1'b0};
				s.tick_count = seg_ticks(c.bit_phase_ticks);
			end
			PH_R_HIGH: begin
				s.line = {1'b1, 1'b1, 1'b0};
				s.tick_count = seg_ticks(c.bit_phase_ticks);
			end
			PH_A_LOW: begin
				s.line = {1'b0, ~s.ack_mode, 1'b1};
				s.tick_count = seg_ticks(c.bit_phase_ticks);
			end
			PH_A_HIGH: begin
				s.line = {1'b1, s.line.sda, 1'b1};
				s.tick_count = seg_ticks(c.bit_phase_ticks);
			end
			default: s.phase = PH_IDLE;
		endcase
	endfunction

	function automatic void close_cmd(inout i2cm_state_t s, input line_t l, inout logic done);
		s.line = l;
		s.phase = PH_IDLE;
		s.tick_count = '0;
		done = 1'b1;
	endfunction

	function automatic void advance_phase(inout i2cm_state_t s, input i2cm_cfg_t c,
		input logic sd, inout logic done);
		case (s.phase)
			PH_ST_A: enter_phase(s, c, PH_ST_B);
			PH_ST_B: close_cmd(s, {1'b0, 1'b0, 1'b1}, done);
			PH_SP_A: enter_phase(s, c, PH_SP_B);
			PH_SP_B: enter_phase(s, c, PH_SP_C);
			PH_SP_C: close_cmd(s, {1'b1, 1'b1, 1'b1}, done);
			PH_W_LOW: enter_phase(s, c, PH_W_HIGH);
			PH_W_HIGH: enter_phase(s, c, PH_W_TAIL);
			PH_W_TAIL: begin
				s.shift_reg = s.shift_reg << 1;
				s.bit_count = s.bit_count + 4'd1;
				enter_phase(s, c, (s.bit_count >= 4'd8) ? PH_ACK_REL : PH_W_LOW);
			end
			PH_ACK_REL: enter_phase(s, c, PH_ACK_WAIT);
			PH_R_LOW: begin
				s.shift_reg = {s.shift_reg[6:0], sd};
				enter_phase(s, c, PH_R_HIGH);
			end
			PH_R_HIGH: begin
				s.bit_count = s.bit_count + 4'd1;
				if (s.bit_count >= 4'd8) begin
					s.rx_hold = s.shift_reg;
					enter_phase(s, c, PH_A_LOW);
				end else begin
					enter_phase(s, c, PH_R_LOW);
				end
			end
			PH_A_LOW: enter_phase(s, c, PH_A_HIGH);
			PH_A_HIGH: close_cmd(s, {1'b0, s.line.sda, 1'b1}, done);
			default: s.phase = PH_IDLE;
		endcase
	endfunction

	function automatic void step_engine(inout i2cm_state_t s, input i2cm_cfg_t c,
		input i2cm_in_t t, output i2cm_out_t r);
		logic done;
		done = 1'b0;
		if (s.phase == PH_IDLE) begin
			if (t.cmd_valid) begin
				s.bit_count = '0;
				case (opcode_t'(t.opcode))
					OP_START: enter_phase(s, c, PH_ST_A);
					OP_STOP: enter_phase(s, c, PH_SP_A);
					OP_WRITE: begin
						s.shift_reg = t.tx_byte;
						enter_phase(s, c, PH_W_LOW);
					end
					default: begin
						s.shift_reg = '0;
						s.ack_mode = t.send_ack;
						enter_phase(s, c, PH_R_LOW);
					end
				endcase
			end
		end else if (s.phase == PH_ACK_WAIT) begin
			if (!t.sda_in) begin
				s.ack_flag = 1'b0;
				close_cmd(s, {1'b0, 1'b1, 1'b0}, done);
			end else if (s.wait_count >= c.ack_timeout) begin
				s.ack_flag = 1'b1;
				enter_phase(s, c, PH_SP_A);
			end else begin
				s.wait_count = s.wait_count + 8'd1;
			end
		end else if (s.tick_count != 8'd0) begin
			s.tick_count = s.tick_count - 8'd1;
		end else begin
			advance_phase(s, c, t.sda_in, done);
		end
		r = '{scl: s.line.scl, sda_level: s.line.sda, sda_drive: s.line.drv,
			busy_res: (s.phase != PH_IDLE), done_res: done, rx_byte: s.rx_hold,
			ack_missing: s.ack_flag};
	endfunction

	// tick generator, steered by its own copy of the sequencer
	function automatic void emit(input logic cv, input logic [1:0] op, input logic [7:0] tx,
		input logic sa, input logic sd);
		i2cm_in_t  it;
		i2cm_out_t scratch;
		it = '{cmd_valid: cv, opcode: op, tx_byte: tx, send_ack: sa, sda_in: sd};
		step_engine(gen_st, gen_cfg, it, scratch);
		tick_q.push_back(it);
		gen_ticks++;
	endfunction

	function automatic void filler();
		logic sd;
		sd = 1'($urandom_range(0, 1));
		if (gen_st.phase == PH_ACK_WAIT) begin
			sd = (ack_hold > 0);
			if (ack_hold > 0)
				ack_hold--;
		end
		emit(($urandom_range(0, 3) == 0), 2'($urandom_range(0, 3)), 8'($urandom),
			1'($urandom_range(0, 1)), sd);
	endfunction

	function automatic void idle_tick();
		emit(1'b0, 2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endfunction

	function automatic void issue(input opcode_t op, input logic [7:0] tx, input logic sa,
		input int polls);
		while (gen_st.phase != PH_IDLE)
			filler();
		ack_hold = polls;
		emit(1'b1, op, tx, sa, 1'($urandom_range(0, 1)));
		while (gen_st.phase != PH_IDLE)
			filler();
	endfunction

	// mostly acked within a few polls, sometimes never
	function automatic int ack_polls();
		return ($urandom_range(0, 7) == 0) ? 999 : $urandom_range(0, 3);
	endfunction

	function automatic void random_traffic(input int n);
		int stop_at;
		stop_at = gen_ticks + n;
		while (gen_ticks < stop_at) begin
			if ($urandom_range(0, 9) < 7) begin
				issue(OP_START, 8'($urandom), 1'($urandom_range(0, 1)), 0);
				issue(OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), ack_polls());
				repeat ($urandom_range(1, 3))
					issue($urandom_range(0, 1) ? OP_WRITE : OP_READ, 8'($urandom),
						1'($urandom_range(0, 1)), ack_polls());
				issue(OP_STOP, 8'($urandom), 1'($urandom_range(0, 1)), 0);
			end else begin
				issue(opcode_t'($urandom_range(0, 3)), 8'($urandom),
					1'($urandom_range(0, 1)), ack_polls());
			end
			repeat ($urandom_range(0, 2))
				idle_tick();
		end
	endfunction

	task automatic report(input string msg);
		if (errors < MAX_LINES)
			$display("mismatch: %s", msg);
		errors++;
	endtask

	task automatic chk(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("beat %0d %s got %0h want %0h", res_count, name, got, want));
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
		@(posedge clk);
		reg_valid <= 1'b1;
		reg_index <= idx;
		reg_data <= val;
		do @(posedge clk); while (!reg_bus.ready);
		reg_valid <= 1'b0;
		case (idx)
			REG_HOLD_TICKS: seq_cfg.hold_ticks = val;
			REG_BIT_PHASE_TICKS: seq_cfg.bit_phase_ticks = val;
			default: seq_cfg.ack_timeout = val;
		endcase
		gen_cfg = seq_cfg;
	endtask

	task automatic set_cfg(input logic [7:0] h, input logic [7:0] b, input logic [7:0] t);
		write_reg(REG_HOLD_TICKS, h);
		write_reg(REG_BIT_PHASE_TICKS, b);
		write_reg(REG_ACK_TIMEOUT, t);
	endtask

	// sender stays quiet until every result is back
	task automatic settle();
		while (tick_q.size() != 0 || beat_valid || line_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// tick driver
	always @(posedge clk) begin
		i2cm_out_t predicted;
		if (!arst_n) begin
			beat_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (beat_valid && cmd_in.ready) begin
				step_engine(seq_st, seq_cfg, beat, predicted);
				line_q.push_back(predicted);
			end
			if (!beat_valid || cmd_in.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					beat_valid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					beat <= tick_q.pop_front();
					beat_valid <= 1'b1;
					send_gap = send_lazy ? $urandom_range(0, 8) : 0;
				end else begin
					beat_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		i2cm_out_t want;
		if (!arst_n) begin
			take_ready <= 1'b0;
			take_gap = 0;
		end else begin
			if (res_out.valid && take_ready) begin
				if (line_q.size() == 0) begin
					report($sformatf("beat %0d arrived with nothing pending", res_count));
				end else begin
					want = line_q.pop_front();
					chk("scl", res_out.scl, want.scl);
					chk("sda_level", res_out.sda_level, want.sda_level);
					chk("sda_drive", res_out.sda_drive, want.sda_drive);
					chk("busy_res", res_out.busy_res, want.busy_res);
					chk("done_res", res_out.done_res, want.done_res);
					chk("rx_byte", res_out.rx_byte, want.rx_byte);
					chk("ack_missing", res_out.ack_missing, want.ack_missing);
				end
				res_count++;
				take_gap = take_lazy ? $urandom_range(0, 8) : 0;
			end
			if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				take_ready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				take_ready <= 1'b0;
			end else begin
				take_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		int quiet;
		if (!arst_n) begin
			quiet = 0;
		end else if ((cmd_in.valid && cmd_in.ready) || (res_out.valid && res_out.ready) ||
			(reg_bus.valid && reg_bus.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("[i2c_master_byte_engine] ERROR");
				$finish;
			end
		end
	end

	initial begin
		seq_st = idle_state();
		gen_st = idle_state();
		seq_cfg = '{hold_ticks: 8'd6, bit_phase_ticks: 8'd2, ack_timeout: 8'd250};
		gen_cfg = seq_cfg;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: every command, ack on the last tolerated poll
		send_lazy = 1'b1;
		take_lazy = 1'b1;
		idle_tick();
		issue(OP_START, 8'h00, 1'b0, 0);
		issue(OP_WRITE, 8'hFF, 1'b0, 0);
		issue(OP_WRITE, 8'h00, 1'b1, 5);
		issue(OP_WRITE, 8'hA5, 1'b0, 250);
		issue(OP_READ, 8'h00, 1'b1, 0);
		issue(OP_READ, 8'hFF, 1'b0, 0);
		issue(OP_STOP, 8'h5A, 1'b1, 0);
		idle_tick();
		settle();

		// zero lengths, timeout on first high poll
		set_cfg(8'd0, 8'd0, 8'd0);
		send_lazy = 1'b0;
		take_lazy = 1'b0;
		issue(OP_WRITE, 8'h5A, 1'b1, 999);
		issue(OP_WRITE, 8'hC3, 1'b0, 0);
		issue(OP_START, 8'h00, 1'b0, 0);
		issue(OP_READ, 8'h3C, 1'b1, 0);
		issue(OP_STOP, 8'h00, 1'b0, 0);
		random_traffic(150);
		settle();

		// shortest nonzero settings with a long output stall
		set_cfg(8'd1, 8'd1, 8'd1);
		send_lazy = 1'b1;
		random_traffic(280);
		hold_req = 1'b1;
		settle();

		// longest timeout, ack on the last tolerated poll
		set_cfg(8'd255, 8'd1, 8'd255);
		issue(OP_WRITE, 8'h81, 1'b0, 255);
		settle();

		repeat (4) begin
			set_cfg(8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
				8'($urandom_range(0, 6)));
			send_lazy = 1'($urandom_range(0, 1));
			take_lazy = 1'($urandom_range(0, 1));
			random_traffic(30);
			settle();
		end

		if (errors == 0)
			$display("[i2c_master_byte_engine] OK");
		else
			$display("[i2c_master_byte_engine] ERROR");
		$finish;
	end

endmodule
